// ----- rtl/compensated_fp_sum_accumulator_macros.svh -----
// ----------------------------------------------------------------------------
// compensated fp sum accumulator assertion macros
// shared assertion shorthands clocked on i_clk with reset masking
// ----------------------------------------------------------------------------
`ifndef COMPENSATED_FP_SUM_ACCUMULATOR_MACROS_SVH
`define COMPENSATED_FP_SUM_ACCUMULATOR_MACROS_SVH

// same-cycle implication, masked while reset is applied
`define CFSA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked while reset is applied
`define CFSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/cfsa_pkg.sv -----
// ----------------------------------------------------------------------------
// cfsa_pkg
// shared constants and helpers for the compensated fp sum accumulator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cfsa_pkg;

    localparam int unsigned DBL_W  = 64;
    localparam int unsigned EXP_W  = 11;
    localparam int unsigned MANT_W = 52;

    typedef logic [DBL_W-1:0] t_dbl;

    localparam t_dbl DBL_ZERO  = 64'h0000_0000_0000_0000;
    localparam t_dbl DBL_QNAN  = 64'h7FF8_0000_0000_0000;
    localparam t_dbl DBL_SIGN  = 64'h8000_0000_0000_0000;

    function automatic logic dbl_is_nan(input t_dbl v);
        return (&v[62:52]) && (|v[51:0]);
    endfunction

    // |a| >= |b|, false when either side is a nan
    function automatic logic dbl_mag_ge(input t_dbl a, input t_dbl b);
        return !dbl_is_nan(a) && !dbl_is_nan(b) && (a[62:0] >= b[62:0]);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/cfsa_fp_add.sv -----
// ----------------------------------------------------------------------------
// cfsa_fp_add
// combinational binary64 adder, round to nearest even, canonical quiet nan
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cfsa_fp_add (
    input  wire cfsa_pkg::t_dbl i_a,
    input  wire cfsa_pkg::t_dbl i_b,
    output cfsa_pkg::t_dbl      o_sum
);

    function automatic logic [5:0] lead_zeros(input logic [55:0] v);
        logic [5:0] n;
        logic       hit;
        n   = 6'd56;
        hit = 1'b0;
        for (int k = 55; k >= 0; k--) begin
            if (!hit && v[k]) begin
                n   = 6'(55 - k);
                hit = 1'b1;
            end
        end
        return n;
    endfunction

    logic        a_nan, b_nan, a_inf, b_inf, swap;
    cfsa_pkg::t_dbl big, sml;
    logic [11:0] e_big, e_sml, e_diff, e_lim, e_n, e_r;
    logic [55:0] sig_big, sig_sml, sml_al, sml_mask;
    logic        sml_st, same_sign;
    logic [56:0] raw;
    logic [55:0] nrm;
    logic [5:0]  lz, sh;
    logic [53:0] m_rnd;
    logic [52:0] m_fin;
    logic        rnd_up;

    always_comb begin
        a_nan = cfsa_pkg::dbl_is_nan(i_a);
        b_nan = cfsa_pkg::dbl_is_nan(i_b);
        a_inf = (&i_a[62:52]) && !(|i_a[51:0]);
        b_inf = (&i_b[62:52]) && !(|i_b[51:0]);

        swap = i_b[62:0] > i_a[62:0];
        big  = swap ? i_b : i_a;
        sml  = swap ? i_a : i_b;
        same_sign = big[63] == sml[63];

        e_big   = (big[62:52] == 11'd0) ? 12'd1 : {1'b0, big[62:52]};
        e_sml   = (sml[62:52] == 11'd0) ? 12'd1 : {1'b0, sml[62:52]};
        sig_big = {(big[62:52] != 11'd0), big[51:0], 3'b000};
        sig_sml = {(sml[62:52] != 11'd0), sml[51:0], 3'b000};
        e_diff  = e_big - e_sml;

        // align the smaller operand, folding shifted-out bits into sticky
        if (e_diff >= 12'd56) begin
            sml_mask = '1;
            sml_al   = '0;
        end else begin
            sml_mask = ~({56{1'b1}} << e_diff[5:0]);
            sml_al   = sig_sml >> e_diff[5:0];
        end
        sml_st = |(sig_sml & sml_mask);
        sml_al = {sml_al[55:1], sml_al[0] | sml_st};

        raw = same_sign ? ({1'b0, sig_big} + {1'b0, sml_al})
                        : ({1'b0, sig_big} - {1'b0, sml_al});

        lz    = lead_zeros(raw[55:0]);
        e_lim = e_big - 12'd1;
        sh    = ({6'd0, lz} > e_lim) ? e_lim[5:0] : lz;
        if (raw[56]) begin
            nrm = {raw[56:2], raw[1] | raw[0]};
            e_n = e_big + 12'd1;
        end else begin
            nrm = raw[55:0] << sh;
            e_n = e_big - {6'd0, sh};
        end

        rnd_up = nrm[2] && (nrm[1] || nrm[0] || nrm[3]);
        m_rnd  = {1'b0, nrm[55:3]} + {53'd0, rnd_up};
        if (m_rnd[53]) begin
            m_fin = m_rnd[53:1];
            e_r   = e_n + 12'd1;
        end else begin
            m_fin = m_rnd[52:0];
            e_r   = e_n;
        end

        if (a_nan || b_nan || (a_inf && b_inf && (i_a[63] != i_b[63]))) begin
            o_sum = cfsa_pkg::DBL_QNAN;
        end else if (a_inf) begin
            o_sum = i_a;
        end else if (b_inf) begin
            o_sum = i_b;
        end else if (m_fin == 53'd0) begin
            // exact zero: positive unless both operands carry the minus sign
            o_sum = same_sign ? {big[63], 63'd0} : cfsa_pkg::DBL_ZERO;
        end else if (e_r >= 12'd2047) begin
            o_sum = {big[63], 11'h7FF, 52'd0};
        end else begin
            o_sum = {big[63], (m_fin[52] ? e_r[10:0] : 11'd0), m_fin[51:0]};
        end
    end

endmodule

`default_nettype wire

// ----- rtl/compensated_fp_sum_accumulator.sv -----
// ----------------------------------------------------------------------------
// compensated_fp_sum_accumulator
// streaming neumaier compensated summation of binary64 values
// ----------------------------------------------------------------------------
// One transaction is accepted per clock cycle while o_stall is low, and each
// produces exactly one total, in order. Each of stages 1 to 5 holds one
// double adder: stage 1 closes the running-sum loop (sum + x), stages 2 and
// 3 form the lost low part, stage 4 closes the compensation loop and stage 5
// adds sum and compensation; stage 6 is the output register. Every stage
// fills whenever it is empty or its successor moves, so transactions keep
// entering while a result waits at the output, until all six stages hold
// one. start_new clears both accumulators for its own transaction,
// subtract flips the addend sign, and any nan total is reported as the
// canonical quiet nan.
`timescale 1ns / 1ps
`default_nettype none

`include "compensated_fp_sum_accumulator_macros.svh"

module compensated_fp_sum_accumulator (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_stall,
    input  wire [63:0]     i_addend,
    input  wire            i_subtract,
    input  wire            i_start_new,
    output logic           o_valid,
    input  wire            i_stall,
    output logic [63:0]    o_total
);

    // stage valids, index 1..6 (6 is the output register)
    logic [6:1] r_v;
    logic [6:1] free;

    // accumulator state
    cfsa_pkg::t_dbl r_sum, r_comp;

    // stage payloads
    cfsa_pkg::t_dbl r1_x;
    logic           r1_start;
    cfsa_pkg::t_dbl r2_sum, r2_x, r2_t;
    logic           r2_start;
    cfsa_pkg::t_dbl r3_d1, r3_other, r3_t;
    logic           r3_start;
    cfsa_pkg::t_dbl r4_d, r4_t;
    logic           r4_start;
    cfsa_pkg::t_dbl r5_t, r5_c;
    cfsa_pkg::t_dbl r6_total;

    cfsa_pkg::t_dbl sum_cur, n_sum, comp_cur, n_comp;
    cfsa_pkg::t_dbl d1_a, d1_b, n_d1, n_other, n_d, n_total;
    logic           mag_ge;

    // a stage may load when empty or when its content moves on
    always_comb begin
        free[6] = !r_v[6] || !i_stall;
        for (int k = 5; k >= 1; k--) begin
            free[k] = !r_v[k] || free[k+1];
        end
    end

    assign o_stall = !free[1];
    assign o_valid = r_v[6];
    assign o_total = r6_total;

    // stage 1: running sum loop
    assign sum_cur = r1_start ? cfsa_pkg::DBL_ZERO : r_sum;
    cfsa_fp_add u_add_sum (.i_a(sum_cur), .i_b(r1_x), .o_sum(n_sum));

    // stage 2: difference against the new sum, ordered by magnitude
    assign mag_ge  = cfsa_pkg::dbl_mag_ge(r2_sum, r2_x);
    assign d1_a    = mag_ge ? r2_sum : r2_x;
    assign d1_b    = r2_t ^ cfsa_pkg::DBL_SIGN;
    assign n_other = mag_ge ? r2_x : r2_sum;
    cfsa_fp_add u_add_d1 (.i_a(d1_a), .i_b(d1_b), .o_sum(n_d1));

    // stage 3: complete the lost low part
    cfsa_fp_add u_add_d (.i_a(r3_d1), .i_b(r3_other), .o_sum(n_d));

    // stage 4: compensation loop
    assign comp_cur = r4_start ? cfsa_pkg::DBL_ZERO : r_comp;
    cfsa_fp_add u_add_comp (.i_a(comp_cur), .i_b(r4_d), .o_sum(n_comp));

    // stage 5: total
    cfsa_fp_add u_add_total (.i_a(r5_t), .i_b(r5_c), .o_sum(n_total));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= '0;
            r_sum  <= cfsa_pkg::DBL_ZERO;
            r_comp <= cfsa_pkg::DBL_ZERO;
        end else begin
            if (free[1]) begin
                r_v[1] <= i_valid;
            end
            for (int k = 2; k <= 6; k++) begin
                if (free[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            if (r_v[1] && free[2]) begin
                r_sum <= n_sum;
            end
            if (r_v[4] && free[5]) begin
                r_comp <= n_comp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (free[1]) begin
            r1_x     <= {i_addend[63] ^ i_subtract, i_addend[62:0]};
            r1_start <= i_start_new;
        end
        if (free[2]) begin
            r2_sum   <= sum_cur;
            r2_x     <= r1_x;
            r2_t     <= n_sum;
            r2_start <= r1_start;
        end
        if (free[3]) begin
            r3_d1    <= n_d1;
            r3_other <= n_other;
            r3_t     <= r2_t;
            r3_start <= r2_start;
        end
        if (free[4]) begin
            r4_d     <= n_d;
            r4_t     <= r3_t;
            r4_start <= r3_start;
        end
        if (free[5]) begin
            r5_t <= r4_t;
            r5_c <= n_comp;
        end
        if (free[6]) begin
            r6_total <= n_total;
        end
    end

    // running sum only moves with a transaction leaving stage 1
    `CFSA_ASSERT_NEXT(a_sum_hold, !(r_v[1] && free[2]), $stable(r_sum), "sum moved while idle")
    // compensation only moves with a transaction leaving stage 4
    `CFSA_ASSERT_NEXT(a_comp_hold, !(r_v[4] && free[5]), $stable(r_comp), "comp moved while idle")
    // a held stage 1 transaction is never dropped
    `CFSA_ASSERT_NEXT(a_s1_keep, r_v[1] && !free[2], r_v[1], "stage 1 transaction lost")
    // input stalls only when every stage is full and the output is held
    `CFSA_ASSERT_NOW(a_stall_full, o_stall, (&r_v) && i_stall, "input stalled with a free stage")

endmodule

`default_nettype wire
